@@ rtl/hid_keyboard_report_tracker_core_macros.svh @@
// Assertion helpers for the keyboard report tracker.
`ifndef HID_KEYBOARD_REPORT_TRACKER_CORE_MACROS_SVH
`define HID_KEYBOARD_REPORT_TRACKER_CORE_MACROS_SVH

`ifndef SYNTH

// Checked at every clock edge outside reset.
`define HKRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define HKRT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define HKRT_ASSERT(lbl, prop, msg)
`define HKRT_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ rtl/hkrt_pkg.sv @@
package hkrt_pkg;

  // Report geometry
  localparam int MAX_SLOTS     = 6;
  localparam int KEY_SLOTS_DEF = 6;
  localparam int CNT_W         = 3;

  // Special scancodes
  localparam logic [7:0] GRAB_RELEASE_CODE = 8'h69;

  localparam logic [7:0] SC_LCTRL  = 8'h25;
  localparam logic [7:0] SC_LSHIFT = 8'h32;
  localparam logic [7:0] SC_LALT   = 8'h40;
  localparam logic [7:0] SC_LMETA  = 8'h85;
  localparam logic [7:0] SC_RCTRL  = 8'h69;
  localparam logic [7:0] SC_RSHIFT = 8'h3e;
  localparam logic [7:0] SC_RALT   = 8'h6c;
  localparam logic [7:0] SC_RMETA  = 8'h87;

  // Event mode codes
  localparam logic MODE_PRESS   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  // Event held in the input register
  typedef struct packed {
    logic       vld;
    logic       mode;
    logic [7:0] scancode;
    logic       auto_repeat;
  } pipe_evt_t;

  // One report as it leaves the tracker
  typedef struct packed {
    logic [7:0]                modifier_mask;
    logic [MAX_SLOTS-1:0][7:0] slot_usage;
    logic [CNT_W-1:0]          held_count;
    logic                      release_grab;
  } report_t;

  // Modifier bit for a scancode, zero for ordinary keys
  function automatic logic [7:0] modifier_bit(input logic [7:0] code);
    logic [7:0] bits;
    unique case (code)
      SC_LCTRL:  bits = 8'h01;
      SC_LSHIFT: bits = 8'h02;
      SC_LALT:   bits = 8'h04;
      SC_LMETA:  bits = 8'h08;
      SC_RCTRL:  bits = 8'h10;
      SC_RSHIFT: bits = 8'h20;
      SC_RALT:   bits = 8'h40;
      SC_RMETA:  bits = 8'h80;
      default:   bits = 8'h00;
    endcase
    return bits;
  endfunction

  // HID usage for an X11 scancode, zero when it is not a report key
  function automatic logic [7:0] usage_of(input logic [7:0] code);
    logic [7:0] u;
    unique case (code)
      8'h09: u = 8'h29;
      8'h0a: u = 8'h1e; 8'h0b: u = 8'h1f; 8'h0c: u = 8'h20; 8'h0d: u = 8'h21;
      8'h0e: u = 8'h22; 8'h0f: u = 8'h23; 8'h10: u = 8'h24; 8'h11: u = 8'h25;
      8'h12: u = 8'h26; 8'h13: u = 8'h27; 8'h14: u = 8'h2d; 8'h15: u = 8'h2e;
      8'h16: u = 8'h2a; 8'h17: u = 8'h2b;
      8'h18: u = 8'h14; 8'h19: u = 8'h1a; 8'h1a: u = 8'h08; 8'h1b: u = 8'h15;
      8'h1c: u = 8'h17; 8'h1d: u = 8'h1c; 8'h1e: u = 8'h18; 8'h1f: u = 8'h0c;
      8'h20: u = 8'h12; 8'h21: u = 8'h13; 8'h22: u = 8'h2f; 8'h23: u = 8'h30;
      8'h24: u = 8'h28;
      8'h26: u = 8'h04; 8'h27: u = 8'h16; 8'h28: u = 8'h07; 8'h29: u = 8'h09;
      8'h2a: u = 8'h0a; 8'h2b: u = 8'h0b; 8'h2c: u = 8'h0d; 8'h2d: u = 8'h0e;
      8'h2e: u = 8'h0f; 8'h2f: u = 8'h33; 8'h30: u = 8'h34; 8'h31: u = 8'h35;
      8'h33: u = 8'h31; 8'h5e: u = 8'h64;
      8'h34: u = 8'h1d; 8'h35: u = 8'h1b; 8'h36: u = 8'h06; 8'h37: u = 8'h19;
      8'h38: u = 8'h05; 8'h39: u = 8'h11; 8'h3a: u = 8'h10; 8'h3b: u = 8'h36;
      8'h3c: u = 8'h37; 8'h3d: u = 8'h38;
      8'h3f: u = 8'h55; 8'h41: u = 8'h2c; 8'h42: u = 8'h39;
      8'h43: u = 8'h3a; 8'h44: u = 8'h3b; 8'h45: u = 8'h3c; 8'h46: u = 8'h3d;
      8'h47: u = 8'h3e; 8'h48: u = 8'h3f; 8'h49: u = 8'h40; 8'h4a: u = 8'h41;
      8'h4b: u = 8'h42; 8'h4c: u = 8'h43; 8'h4d: u = 8'h53; 8'h4e: u = 8'h47;
      8'h4f: u = 8'h5f; 8'h50: u = 8'h60; 8'h51: u = 8'h61; 8'h52: u = 8'h56;
      8'h53: u = 8'h5c; 8'h54: u = 8'h5d; 8'h55: u = 8'h5e; 8'h56: u = 8'h57;
      8'h57: u = 8'h59; 8'h58: u = 8'h5a; 8'h59: u = 8'h5b; 8'h5a: u = 8'h62;
      8'h5b: u = 8'h63;
      8'h5f: u = 8'h44; 8'h60: u = 8'h45; 8'h68: u = 8'h58; 8'h6a: u = 8'h54;
      8'h6b: u = 8'h46;
      8'h6e: u = 8'h4a; 8'h6f: u = 8'h52; 8'h70: u = 8'h4b; 8'h71: u = 8'h50;
      8'h72: u = 8'h4f; 8'h73: u = 8'h4d; 8'h74: u = 8'h51; 8'h75: u = 8'h4e;
      8'h76: u = 8'h49; 8'h77: u = 8'h4c; 8'h7f: u = 8'h48;
      default: u = 8'h00;
    endcase
    return u;
  endfunction

endpackage

@@ rtl/hkrt_if.sv @@
// Key event channel
interface hkrt_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] scancode;
  logic       auto_repeat;

  modport source (output valid, mode, scancode, auto_repeat, input ready);
  modport sink   (input valid, mode, scancode, auto_repeat, output ready);
endinterface

// Report channel
interface hkrt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] modifier_mask;
  logic [7:0] slot0_usage;
  logic [7:0] slot1_usage;
  logic [7:0] slot2_usage;
  logic [7:0] slot3_usage;
  logic [7:0] slot4_usage;
  logic [7:0] slot5_usage;
  logic [2:0] held_count;
  logic       release_grab;

  modport source (
    output valid, modifier_mask, slot0_usage, slot1_usage, slot2_usage,
           slot3_usage, slot4_usage, slot5_usage, held_count, release_grab,
    input  ready
  );
  modport sink (
    input  valid, modifier_mask, slot0_usage, slot1_usage, slot2_usage,
           slot3_usage, slot4_usage, slot5_usage, held_count, release_grab,
    output ready
  );
endinterface

@@ rtl/hkrt_in_stage.sv @@
module hkrt_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  hkrt_in_if.sink            in_ch,
  input  logic               adv,
  output hkrt_pkg::pipe_evt_t evt
);
  import hkrt_pkg::*;

  logic       vld_r, vld_nxt;
  logic       mode_r;
  logic [7:0] scancode_r;
  logic       auto_repeat_r;
  logic       take;

  // Accept while empty or while the held event moves on
  assign in_ch.ready = !vld_r || adv;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (adv) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Capture the event on transfer
  always_ff @(posedge clk) begin
    if (take) begin
      mode_r        <= in_ch.mode;
      scancode_r    <= in_ch.scancode;
      auto_repeat_r <= in_ch.auto_repeat;
    end
  end

  assign evt.vld         = vld_r;
  assign evt.mode        = mode_r;
  assign evt.scancode    = scancode_r;
  assign evt.auto_repeat = auto_repeat_r;

endmodule

@@ rtl/hkrt_tracker.sv @@
`include "hid_keyboard_report_tracker_core_macros.svh"

module hkrt_tracker #(
  parameter int KEY_SLOTS = hkrt_pkg::KEY_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  hkrt_pkg::pipe_evt_t evt,
  input  logic                adv,
  output logic                rpt_vld,
  output hkrt_pkg::report_t   rpt
);
  import hkrt_pkg::*;

  logic [7:0]       modifier_r, modifier_nxt;
  logic [CNT_W-1:0] total_r, total_nxt;
  logic [7:0]       held_r   [KEY_SLOTS];
  logic [7:0]       held_nxt [KEY_SLOTS];

  logic [7:0]       push_list [KEY_SLOTS];
  logic [7:0]       pull_list [KEY_SLOTS];
  logic [CNT_W-1:0] pos       [KEY_SLOTS];
  logic [KEY_SLOTS-1:0] keep;
  logic [CNT_W-1:0] pull_total;
  logic [CNT_W-1:0] base;
  logic             full;
  logic             known;
  logic             grab;
  logic             upd;
  logic             is_press;
  logic [7:0]       mod_bit;

  // Decode the event
  assign is_press = (evt.mode == MODE_PRESS);
  assign known    = (usage_of(evt.scancode) != 8'h00);
  assign mod_bit  = modifier_bit(evt.scancode);
  assign grab     = is_press && (evt.scancode == GRAB_RELEASE_CODE);
  assign upd      = adv && !evt.auto_repeat && !grab;
  assign rpt_vld  = !evt.auto_repeat;

  // Press: drop the oldest when full, then append at base
  assign full = (total_r >= CNT_W'(KEY_SLOTS));
  assign base = full ? CNT_W'(KEY_SLOTS - 1) : total_r;

  for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_push
    logic [7:0] shifted;
    if (i < KEY_SLOTS - 1) begin : g_mid
      assign shifted = full ? held_r[i+1] : held_r[i];
    end else begin : g_last
      assign shifted = held_r[i];
    end
    assign push_list[i] = (CNT_W'(i) == base) ? evt.scancode : shifted;
  end

  // Release: remove every copy of the key and close up the list
  always_comb begin
    logic [CNT_W-1:0] cnt;
    cnt = '0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      keep[i] = (CNT_W'(i) < total_r) && (held_r[i] != evt.scancode);
      pos[i]  = cnt;
      cnt     = cnt + CNT_W'(keep[i]);
    end
    pull_total = cnt;
  end

  always_comb begin
    for (int k = 0; k < KEY_SLOTS; k++) begin
      pull_list[k] = held_r[k];
      for (int i = k; i < KEY_SLOTS; i++) begin
        if (keep[i] && (pos[i] == CNT_W'(k))) begin
          pull_list[k] = held_r[i];
        end
      end
    end
  end

  // Select the next state
  always_comb begin
    modifier_nxt = modifier_r;
    total_nxt    = total_r;
    held_nxt     = held_r;
    if (upd) begin
      if (is_press) begin
        modifier_nxt = modifier_r | mod_bit;
        if (known) begin
          held_nxt  = push_list;
          total_nxt = base + CNT_W'(1);
        end
      end else begin
        modifier_nxt = modifier_r & ~mod_bit;
        if (known) begin
          held_nxt  = pull_list;
          total_nxt = pull_total;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modifier_r <= '0;
      total_r    <= '0;
    end else begin
      modifier_r <= modifier_nxt;
      total_r    <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      held_r <= held_nxt;
    end
  end

  // Build the report from the updated state
  assign rpt.modifier_mask = modifier_nxt;
  assign rpt.held_count    = total_nxt;
  assign rpt.release_grab  = grab;

  for (genvar j = 0; j < MAX_SLOTS; j++) begin : g_slot
    if (j < KEY_SLOTS) begin : g_used
      assign rpt.slot_usage[j] = (CNT_W'(j) < total_nxt) ? usage_of(held_nxt[j]) : 8'h00;
    end else begin : g_unused
      assign rpt.slot_usage[j] = 8'h00;
    end
  end

  `HKRT_ASSERT(a_total_bound, total_r <= CNT_W'(KEY_SLOTS), "held count above slot count")
  `HKRT_ASSERT(a_push_grows, upd && is_press && known && !full |=> total_r == CNT_W'($past(total_r) + CNT_W'(1)), "press did not add a key")
  `HKRT_ASSERT(a_grab_holds, adv && !evt.auto_repeat && grab |=> $stable(modifier_r) && $stable(total_r), "grab key changed state")
  `HKRT_ASSERT(a_pull_shrinks, upd && !is_press |=> total_r <= $past(total_r), "release grew the list")

endmodule

@@ rtl/hkrt_out_stage.sv @@
`include "hid_keyboard_report_tracker_core_macros.svh"

module hkrt_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  hkrt_pkg::pipe_evt_t evt,
  input  logic              rpt_vld,
  input  hkrt_pkg::report_t rpt,
  output logic              adv,
  hkrt_out_if.source        out_ch
);
  import hkrt_pkg::*;

  logic    vld_r, vld_nxt;
  report_t rpt_r;

  // Move the held event on when the result register is empty or its result is taken
  assign adv = evt.vld && (!vld_r || out_ch.ready);

  always_comb begin
    vld_nxt = vld_r;
    if (adv) begin
      vld_nxt = rpt_vld;
    end else if (out_ch.ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Load the report on advance
  always_ff @(posedge clk) begin
    if (adv) begin
      rpt_r <= rpt;
    end
  end

  assign out_ch.valid         = vld_r;
  assign out_ch.modifier_mask = rpt_r.modifier_mask;
  assign out_ch.slot0_usage   = rpt_r.slot_usage[0];
  assign out_ch.slot1_usage   = rpt_r.slot_usage[1];
  assign out_ch.slot2_usage   = rpt_r.slot_usage[2];
  assign out_ch.slot3_usage   = rpt_r.slot_usage[3];
  assign out_ch.slot4_usage   = rpt_r.slot_usage[4];
  assign out_ch.slot5_usage   = rpt_r.slot_usage[5];
  assign out_ch.held_count    = rpt_r.held_count;
  assign out_ch.release_grab  = rpt_r.release_grab;

  `HKRT_ASSERT_ALWAYS(a_no_adv_in_reset, !rst_n |=> !vld_r, "result valid right after reset")
  `HKRT_ASSERT(a_repeat_silent, adv && evt.auto_repeat |=> !vld_r, "autorepeat produced a result")

endmodule

@@ rtl/hid_keyboard_report_tracker_core.sv @@
// Channel  Dir  Handshake        Payload
// in_ch    in   valid/ready      mode, scancode, auto_repeat
// out_ch   out  valid/ready      modifier_mask, slot0..5_usage, held_count, release_grab
//
// One event per cycle sustained while the result is not stalled; each event passes the event
// register, which feeds the combinational key list update, and then the result register.
// Autorepeat events pass through and give no result.
// Synchronous active-low reset clears the modifier mask, held count and both valid flags.
// A stalled result holds the event register; input ready follows the result register.
module hid_keyboard_report_tracker_core #(
  parameter int KEY_SLOTS = hkrt_pkg::KEY_SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  hkrt_in_if.sink    in_ch,
  hkrt_out_if.source out_ch
);
  import hkrt_pkg::*;

  pipe_evt_t evt;
  report_t   rpt;
  logic      rpt_vld;
  logic      adv;

  hkrt_in_stage u_in_stage (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .adv   (adv),
    .evt   (evt)
  );

  hkrt_tracker #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_tracker (
    .clk     (clk),
    .rst_n   (rst_n),
    .evt     (evt),
    .adv     (adv),
    .rpt_vld (rpt_vld),
    .rpt     (rpt)
  );

  hkrt_out_stage u_out_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .evt     (evt),
    .rpt_vld (rpt_vld),
    .rpt     (rpt),
    .adv     (adv),
    .out_ch  (out_ch)
  );

endmodule
